// File: design/imm32alu_pkg.sv
package imm32alu_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned OP_W    = 4;
    localparam int unsigned SHAMT_W = 8;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned IN_W    = 80;
    localparam int unsigned OUT_W   = 40;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 4'd0,
        OP_OR  = 4'd1,
        OP_AND = 4'd2,
        OP_SUB = 4'd3,
        OP_XOR = 4'd4,
        OP_CMP = 4'd5,
        OP_MOV = 4'd6,
        OP_SHL = 4'd7,
        OP_SHR = 4'd8,
        OP_SAR = 4'd9
    } t_op;

    typedef struct packed {
        logic s;
        logic z;
        logic o;
        logic c;
    } t_flags;

endpackage

// File: design/imm32_alu_with_flags.sv
// 32-bit integer alu with x86 style status flags kept between items
// slave side: i_s_tvalid / o_s_tready / i_s_tdata carry one operation item
// master side: o_m_tvalid / i_m_tready / o_m_tdata carry one result item
// every accepted item gives exactly one result item, in order
// an item is first captured in an input register, then one pass of logic
// (33-bit add or subtract, barrel shift, flag rules) fills the result register
// throughput: one item per cycle while the receiver keeps up; set by the four-bit flag
// feedback loop, which closes on the flag register through the flag logic
// the sign, zero, overflow and carry flags are registered with each result (move and
// unused codes keep them), so the flags of one item are seen by the next with no bubble
// when the receiver stalls the result holds; the input register still takes
// an item if it is empty, after that o_s_tready falls until the result moves
// reset (i_rst_n low, synchronous) empties both registers and clears all flags
// unused operation codes pass the operand through with write-back clear
module imm32_alu_with_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // operation[3:0], operand_value[35:4], immediate_value[67:36],
    // shift_amount[75:68], zero fill[79:76]
    input  logic [79:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // result_value[31:0], write_back[32], sign_out[33], zero_out[34],
    // overflow_out[35], carry_out[36], zero fill[39:37]
    output logic [39:0] o_m_tdata
);

    localparam int unsigned W = imm32alu_pkg::WORD_W;

    logic                                   r_in_valid;
    imm32alu_pkg::t_op                      r_op;
    logic [W-1:0]                           r_a;
    logic [W-1:0]                           r_b;
    logic [imm32alu_pkg::CNT_W-1:0]         r_cnt;

    logic                                   r_out_valid;
    logic [W-1:0]                           r_result;
    logic                                   r_wb;
    imm32alu_pkg::t_flags                   r_flags;

    logic                                   w_out_free;
    logic                                   w_load;
    logic                                   w_take;
    logic [W:0]                             w_sum;
    logic [W:0]                             w_diff;
    logic                                   w_add_ov;
    logic                                   w_sub_ov;
    logic [W-1:0]                           n_result;
    logic                                   n_wb;
    imm32alu_pkg::t_flags                   n_flags;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_load     = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;
    assign w_take     = i_s_tvalid && o_s_tready;

    assign w_sum    = {1'b0, r_a} + {1'b0, r_b};
    assign w_diff   = {1'b0, r_a} - {1'b0, r_b};
    assign w_add_ov = ~(r_a[W-1] ^ r_b[W-1]) & (r_a[W-1] ^ w_sum[W-1]);
    assign w_sub_ov = (r_a[W-1] ^ r_b[W-1]) & (r_a[W-1] ^ w_diff[W-1]);

    always_comb begin
        n_result = r_a;
        n_wb     = 1'b1;
        n_flags  = r_flags;
        case (r_op)
            imm32alu_pkg::OP_ADD: begin
                n_result  = w_sum[W-1:0];
                n_flags.o = w_add_ov;
                n_flags.c = w_sum[W];
            end
            imm32alu_pkg::OP_OR: begin
                n_result  = r_a | r_b;
                n_flags.o = 1'b0;
                n_flags.c = 1'b0;
            end
            imm32alu_pkg::OP_AND: begin
                n_result  = r_a & r_b;
                n_flags.o = 1'b0;
                n_flags.c = 1'b0;
            end
            imm32alu_pkg::OP_XOR: begin
                n_result  = r_a ^ r_b;
                n_flags.o = 1'b0;
                n_flags.c = 1'b0;
            end
            imm32alu_pkg::OP_SUB, imm32alu_pkg::OP_CMP: begin
                n_result  = w_diff[W-1:0];
                n_flags.o = w_sub_ov;
                n_flags.c = w_diff[W];
            end
            imm32alu_pkg::OP_MOV: begin
                n_result = r_b;
            end
            imm32alu_pkg::OP_SHL: begin
                n_result = r_a << r_cnt;
                if (r_cnt == imm32alu_pkg::CNT_W'(1)) begin
                    n_flags.o = r_a[W-1] ^ r_a[W-2];
                end
            end
            imm32alu_pkg::OP_SHR: begin
                n_result = r_a >> r_cnt;
                if (r_cnt == imm32alu_pkg::CNT_W'(1)) begin
                    n_flags.o = r_a[W-1];
                end
            end
            imm32alu_pkg::OP_SAR: begin
                n_result = W'($signed(r_a) >>> r_cnt);
                if (r_cnt == imm32alu_pkg::CNT_W'(1)) begin
                    n_flags.o = 1'b0;
                end
            end
            default: begin
                n_result = r_a;
                n_wb     = 1'b0;
            end
        endcase
        case (r_op)
            imm32alu_pkg::OP_ADD, imm32alu_pkg::OP_OR, imm32alu_pkg::OP_AND,
            imm32alu_pkg::OP_SUB, imm32alu_pkg::OP_XOR, imm32alu_pkg::OP_CMP,
            imm32alu_pkg::OP_SHL, imm32alu_pkg::OP_SHR, imm32alu_pkg::OP_SAR: begin
                n_flags.s = n_result[W-1];
                n_flags.z = (n_result == '0);
            end
            default: begin
            end
        endcase
        // compare keeps the operand as its result and is not stored
        if (r_op == imm32alu_pkg::OP_CMP) begin
            n_result = r_a;
            n_wb     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (w_take) begin
            r_op  <= imm32alu_pkg::t_op'(i_s_tdata[3:0]);
            r_a   <= i_s_tdata[35:4];
            r_b   <= i_s_tdata[67:36];
            r_cnt <= i_s_tdata[72:68];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_load) begin
                r_flags <= n_flags;
            end
        end
        if (w_load) begin
            r_result <= n_result;
            r_wb     <= n_wb;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_flags.c, r_flags.o, r_flags.z, r_flags.s, r_wb, r_result};

    a_reset_flags: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (r_flags == '0) && !r_out_valid)
        else $error("flags or output valid not cleared by reset");

    a_cmp_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_op == imm32alu_pkg::OP_CMP) |=> !r_wb && (r_result == $past(r_a)))
        else $error("compare result written back or altered");

    a_mov_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_op == imm32alu_pkg::OP_MOV) |=> $stable(r_flags))
        else $error("move changed the flags");

    a_logic_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_op == imm32alu_pkg::OP_OR || r_op == imm32alu_pkg::OP_AND ||
                    r_op == imm32alu_pkg::OP_XOR)) |=> !r_flags.c && !r_flags.o)
        else $error("logic operation left carry or overflow set");

    a_shift_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_op == imm32alu_pkg::OP_SHL || r_op == imm32alu_pkg::OP_SHR ||
                    r_op == imm32alu_pkg::OP_SAR)) |=> $stable(r_flags.c))
        else $error("shift changed carry");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> r_out_valid && $stable(r_flags))
        else $error("flags moved while result stalled");

endmodule

// File: tb/imm32_alu_with_flags_tb.sv
`timescale 1ns / 100ps

module imm32_alu_with_flags_tb;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 1150;

    // fields from the lowest bit up: operation, operand, immediate, shift amount, fill
    typedef struct packed {
        logic [3:0]  fill;
        logic [7:0]  shamt;
        logic [31:0] imm;
        logic [31:0] opnd;
        logic [3:0]  op;
    } t_alu_op_item;

    // fields from the lowest bit up: result, write-back, sign, zero, overflow, carry, fill
    typedef struct packed {
        logic [2:0]  fill;
        logic        carry;
        logic        ovf;
        logic        zero;
        logic        sign;
        logic        wb;
        logic [31:0] result;
    } t_alu_res_item;

    class alu_flag_scoreboard;
        imm32alu_pkg::t_flags flags;
        t_alu_res_item        expected_results[$];
        int unsigned          errors;

        function new();
            flags  = '0;
            errors = 0;
        endfunction

        function void set_sign_zero(logic [31:0] r);
            flags.s = r[31];
            flags.z = (r == 32'd0);
        endfunction

        function void note_op(t_alu_op_item it);
            logic [31:0]   a;
            logic [31:0]   b;
            logic [31:0]   r;
            logic [32:0]   wide;
            logic [4:0]    cnt;
            logic          wb;
            t_alu_res_item res;
            a   = it.opnd;
            b   = it.imm;
            cnt = it.shamt[4:0];
            r   = a;
            wb  = 1'b1;
            case (it.op)
                imm32alu_pkg::OP_ADD: begin
                    wide = {1'b0, a} + {1'b0, b};
                    r = wide[31:0];
                    set_sign_zero(r);
                    flags.o = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
                    flags.c = wide[32];
                end
                imm32alu_pkg::OP_OR, imm32alu_pkg::OP_AND, imm32alu_pkg::OP_XOR: begin
                    if (it.op == imm32alu_pkg::OP_OR)
                        r = a | b;
                    else if (it.op == imm32alu_pkg::OP_AND)
                        r = a & b;
                    else
                        r = a ^ b;
                    set_sign_zero(r);
                    flags.o = 1'b0;
                    flags.c = 1'b0;
                end
                imm32alu_pkg::OP_SUB, imm32alu_pkg::OP_CMP: begin
                    wide = {1'b0, a} - {1'b0, b};
                    r = wide[31:0];
                    set_sign_zero(r);
                    flags.o = (a[31] ^ b[31]) & (a[31] ^ r[31]);
                    flags.c = wide[32];
                    if (it.op == imm32alu_pkg::OP_CMP) begin
                        r  = a;
                        wb = 1'b0;
                    end
                end
                imm32alu_pkg::OP_MOV: begin
                    r = b;
                end
                imm32alu_pkg::OP_SHL: begin
                    if (cnt == 5'd1)
                        flags.o = a[31] ^ a[30];
                    r = a << cnt;
                    set_sign_zero(r);
                end
                imm32alu_pkg::OP_SHR: begin
                    if (cnt == 5'd1)
                        flags.o = a[31];
                    r = a >> cnt;
                    set_sign_zero(r);
                end
                imm32alu_pkg::OP_SAR: begin
                    if (cnt == 5'd1)
                        flags.o = 1'b0;
                    r = $signed(a) >>> cnt;
                    set_sign_zero(r);
                end
                default: begin
                    r  = a;
                    wb = 1'b0;
                end
            endcase
            res        = '0;
            res.result = r;
            res.wb     = wb;
            res.sign   = flags.s;
            res.zero   = flags.z;
            res.ovf    = flags.o;
            res.carry  = flags.c;
            expected_results = {expected_results, res};
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v) begin
                $error("%s: expected %h, actual %h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_res(t_alu_res_item got);
            t_alu_res_item exp_r;
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected: %h", got);
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            compare_field("result_value", exp_r.result, got.result);
            compare_field("write_back", 32'(exp_r.wb), 32'(got.wb));
            compare_field("sign_out", 32'(exp_r.sign), 32'(got.sign));
            compare_field("zero_out", 32'(exp_r.zero), 32'(got.zero));
            compare_field("overflow_out", 32'(exp_r.ovf), 32'(got.ovf));
            compare_field("carry_out", 32'(exp_r.carry), 32'(got.carry));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [79:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;

    alu_flag_scoreboard flag_sb;
    logic               calm = 1'b0;
    int unsigned        cycle_count = 0;

    imm32_alu_with_flags u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(99) >= 13);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                flag_sb.note_op(t_alu_op_item'(i_s_tdata));
            if (o_m_tvalid && i_m_tready)
                flag_sb.check_res(t_alu_res_item'(o_m_tdata));
        end
    end

    task automatic send_op(input logic [3:0] op, input logic [31:0] opnd,
                           input logic [31:0] imm, input logic [7:0] shamt);
        t_alu_op_item it;
        it       = '0;
        it.op    = op;
        it.opnd  = opnd;
        it.imm   = imm;
        it.shamt = shamt;
        if (!calm && $urandom_range(99) < 13) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= it;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h4000_0000;
            5: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [3:0]  op;
        logic [31:0] opnd;
        logic [31:0] imm;
        logic [7:0]  shamt;
        flag_sb    = new();
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes of add, sub and compare
        send_op(imm32alu_pkg::OP_ADD, 32'h7fff_ffff, 32'h0000_0001, 8'd0);
        send_op(imm32alu_pkg::OP_ADD, 32'hffff_ffff, 32'h0000_0001, 8'd0);
        send_op(imm32alu_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 8'd0);
        send_op(imm32alu_pkg::OP_SUB, 32'h0000_0000, 32'h0000_0001, 8'd0);
        send_op(imm32alu_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001, 8'd0);
        send_op(imm32alu_pkg::OP_CMP, 32'h1234_5678, 32'h1234_5678, 8'd0);
        send_op(imm32alu_pkg::OP_CMP, 32'h0000_0001, 32'hffff_ffff, 8'd0);
        // logic ops clear carry and overflow
        send_op(imm32alu_pkg::OP_OR,  32'h0f0f_0f0f, 32'hf0f0_f0f0, 8'hff);
        send_op(imm32alu_pkg::OP_AND, 32'haaaa_aaaa, 32'h5555_5555, 8'hff);
        send_op(imm32alu_pkg::OP_XOR, 32'hffff_ffff, 32'h7fff_ffff, 8'hff);
        // move leaves flags alone
        send_op(imm32alu_pkg::OP_SUB, 32'h0000_0000, 32'h0000_0001, 8'd0);
        send_op(imm32alu_pkg::OP_MOV, 32'h0000_0000, 32'h8000_0000, 8'd0);
        // shifts, masked counts and carry left as it stands
        send_op(imm32alu_pkg::OP_SHL, 32'h4000_0000, 32'h0, 8'd1);
        send_op(imm32alu_pkg::OP_SHL, 32'h8000_0000, 32'h0, 8'd0);
        send_op(imm32alu_pkg::OP_SHL, 32'hffff_ffff, 32'h0, 8'hff);
        send_op(imm32alu_pkg::OP_SHR, 32'h8000_0000, 32'h0, 8'd1);
        send_op(imm32alu_pkg::OP_SHR, 32'hffff_ffff, 32'h0, 8'h20);
        send_op(imm32alu_pkg::OP_SHR, 32'h8000_0000, 32'h0, 8'd31);
        send_op(imm32alu_pkg::OP_SAR, 32'h8000_0000, 32'h0, 8'd1);
        send_op(imm32alu_pkg::OP_SAR, 32'h8000_0000, 32'h0, 8'hdf);
        send_op(imm32alu_pkg::OP_SAR, 32'h7fff_ffff, 32'h0, 8'd30);
        // unused codes pass the operand through
        send_op(4'd10, 32'hdead_beef, 32'h0, 8'd0);
        send_op(4'd15, 32'h0000_0000, 32'hffff_ffff, 8'hff);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm <= (n >= 500 && n < 700);
            if ($urandom_range(99) < 6)
                op = 4'($urandom_range(15, 10));
            else
                op = 4'($urandom_range(9, 0));
            opnd = pick_word();
            imm  = ($urandom_range(9) == 0) ? opnd : pick_word();
            case ($urandom_range(5))
                0: shamt = 8'd1;
                1: shamt = {3'($urandom_range(7)), 5'd1};
                2: shamt = {3'($urandom_range(7)), 5'd0};
                default: shamt = 8'($urandom_range(255));
            endcase
            send_op(op, opnd, imm, shamt);
        end
        i_s_tvalid <= 1'b0;
        calm       <= 1'b0;

        while (flag_sb.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (flag_sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
design/imm32alu_pkg.sv
design/imm32_alu_with_flags.sv
tb/imm32_alu_with_flags_tb.sv
